@@ sv/fbi_pkg.sv @@
// Shared types, constants and tables for the fuzzy beacon interval block.
// No dependencies; imported by every module of the block except fbi_ctl.
package fbi_pkg;

  // Membership values, Q1.12 in 0..4096
  localparam int unsigned MF_W = 13;
  typedef logic [MF_W-1:0] mf_t;
  typedef mf_t [4:0] mf_vec_t;

  // Scaled speed domain: v = 5 * speed_q, breakpoint = 128 * tenths
  localparam int unsigned V_W  = 17;
  localparam int unsigned D_W  = 15;   // distance from the segment's low or high breakpoint
  localparam int unsigned NW   = 28;   // numerator of a membership division

  typedef enum logic [1:0] {SHAPE_Z, SHAPE_TRI, SHAPE_S} shape_e;
  typedef enum logic [1:0] {SEG_ZERO, SEG_FULL, SEG_LO, SEG_HI} seg_e;

  // Speed sets: very low, low, medium, high, very high
  localparam shape_e SET_SHAPE [5] = '{SHAPE_Z, SHAPE_TRI, SHAPE_TRI, SHAPE_TRI, SHAPE_S};
  localparam logic [V_W-1:0] SET_LO  [5] = '{17'd7040,  17'd1664,  17'd4096,
                                             17'd24832, 17'd34048};
  localparam logic [V_W-1:0] SET_MID [5] = '{17'd12224, 17'd13760, 17'd25472,
                                             17'd37568, 17'd42624};
  localparam logic [V_W-1:0] SET_HI  [5] = '{17'd17408, 17'd25856, 17'd46848,
                                             17'd50304, 17'd51200};
  // Divisor and rounding offset of the reduced membership fraction
  localparam int unsigned SET_DIV  [5] = '{13122, 189, 334, 199, 35912};
  localparam int unsigned SET_HALF [5] = '{6561, 94, 167, 99, 17956};

  // Interval classes and rule map (row: speed set, column: neighbor set)
  typedef enum logic [2:0] {
    CLS_VSHORT, CLS_SHORT, CLS_MEDIUM, CLS_LONG, CLS_VLONG
  } cls_e;

  localparam cls_e RULE_CLASS [5][5] = '{
    '{CLS_MEDIUM, CLS_MEDIUM, CLS_LONG,   CLS_LONG,   CLS_VLONG},
    '{CLS_MEDIUM, CLS_MEDIUM, CLS_MEDIUM, CLS_LONG,   CLS_VLONG},
    '{CLS_SHORT,  CLS_SHORT,  CLS_MEDIUM, CLS_LONG,   CLS_LONG},
    '{CLS_VSHORT, CLS_SHORT,  CLS_MEDIUM, CLS_MEDIUM, CLS_MEDIUM},
    '{CLS_VSHORT, CLS_SHORT,  CLS_SHORT,  CLS_MEDIUM, CLS_MEDIUM}
  };

  // Class centroids in hundredths of a second
  localparam int unsigned CENTROID [5] = '{100, 170, 305, 415, 500};

  // Aggregation and final division widths
  localparam int unsigned WS_W  = 17;  // sum of strengths
  localparam int unsigned CS_W  = 26;  // strength-weighted centroid sum
  localparam int unsigned DEN_W = 24;  // 100 * strength sum
  localparam int unsigned RW    = 35;  // 256 * centroid sum plus rounding
  localparam int unsigned QW    = 11;  // interval, Q3.8

  typedef struct packed {
    logic [RW-1:0]    num;
    logic [DEN_W-1:0] den;
    logic             no_act;
  } div_req_t;

  // Neighbor memberships for a clipped count; every count of 30 or more is alike
  function automatic mf_vec_t nbr_mf(input logic [7:0] n);
    mf_vec_t r;
    case (n)
      8'd0, 8'd1, 8'd2: r = {13'd0, 13'd0, 13'd0, 13'd0, 13'd4096};
      8'd3:  r = {13'd0, 13'd0,    13'd0,    13'd585,  13'd3929};
      8'd4:  r = {13'd0, 13'd0,    13'd315,  13'd1170, 13'd3427};
      8'd5:  r = {13'd0, 13'd0,    13'd630,  13'd1755, 13'd2591};
      8'd6:  r = {13'd0, 13'd0,    13'd945,  13'd2341, 13'd1505};
      8'd7:  r = {13'd0, 13'd0,    13'd1260, 13'd2926, 13'd669};
      8'd8:  r = {13'd0, 13'd0,    13'd1575, 13'd3511, 13'd167};
      8'd9:  r = {13'd0, 13'd0,    13'd1890, 13'd4096, 13'd0};
      8'd10: r = {13'd0, 13'd0,    13'd2206, 13'd3511, 13'd0};
      8'd11: r = {13'd0, 13'd0,    13'd2521, 13'd2926, 13'd0};
      8'd12: r = {13'd0, 13'd0,    13'd2836, 13'd2341, 13'd0};
      8'd13: r = {13'd0, 13'd0,    13'd3151, 13'd1755, 13'd0};
      8'd14: r = {13'd0, 13'd0,    13'd3466, 13'd1170, 13'd0};
      8'd15: r = {13'd0, 13'd0,    13'd3781, 13'd585,  13'd0};
      8'd16: r = {13'd0, 13'd0,    13'd4096, 13'd0,    13'd0};
      8'd17: r = {13'd0, 13'd585,  13'd3781, 13'd0,    13'd0};
      8'd18: r = {13'd0, 13'd1170, 13'd3466, 13'd0,    13'd0};
      8'd19: r = {13'd0, 13'd1755, 13'd3151, 13'd0,    13'd0};
      8'd20: r = {13'd0, 13'd2341, 13'd2836, 13'd0,    13'd0};
      8'd21: r = {13'd0, 13'd2926, 13'd2521, 13'd0,    13'd0};
      8'd22: r = {13'd0, 13'd3511, 13'd2206, 13'd0,    13'd0};
      8'd23: r = {13'd0, 13'd4096, 13'd1890, 13'd0,    13'd0};
      8'd24: r = {13'd167,  13'd3511, 13'd1575, 13'd0, 13'd0};
      8'd25: r = {13'd669,  13'd2926, 13'd1260, 13'd0, 13'd0};
      8'd26: r = {13'd1505, 13'd2341, 13'd945,  13'd0, 13'd0};
      8'd27: r = {13'd2591, 13'd1755, 13'd630,  13'd0, 13'd0};
      8'd28: r = {13'd3427, 13'd1170, 13'd315,  13'd0, 13'd0};
      8'd29: r = {13'd3929, 13'd585,  13'd0,    13'd0, 13'd0};
      default: r = {13'd4096, 13'd0, 13'd0, 13'd0, 13'd0};
    endcase
    return r;
  endfunction

endpackage

@@ sv/fbi_ctl.sv @@
// Pipeline control: per-stage valid bits and stage enables for the block.
// Depends on nothing but the clock and reset.
module fbi_ctl #(
  parameter int unsigned DEPTH = 19
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [DEPTH-1:0] en_o
);

  logic [DEPTH-1:0] v_q;

  // A stage may load when the output is ready or it or any stage after it holds a bubble
  always_comb begin
    en_o[DEPTH-1] = out_ready_i || !v_q[DEPTH-1];
    for (int k = DEPTH-2; k >= 0; k--) begin
      en_o[k] = en_o[k+1] || !v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        if (en_o[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_ready_o  = en_o[0];
  assign out_valid_o = v_q[DEPTH-1];

endmodule

@@ sv/fbi_cdiv.sv @@
// Pipelined division by a fixed divisor (reciprocal multiply plus one correction).
// Depends on fbi_pkg for widths.
module fbi_cdiv
  import fbi_pkg::*;
#(
  parameter int unsigned DIVISOR = 189
) (
  input  logic          clk_i,
  input  logic [1:0]    en_i,
  input  logic [NW-1:0] num_i,
  output mf_t           q_o
);

  localparam longint unsigned RECIP_L = (longint'(1) << NW) / DIVISOR;
  localparam int unsigned     MW      = $clog2(RECIP_L + 1);
  localparam logic [MW-1:0]   RECIP   = MW'(RECIP_L);
  localparam logic [NW-1:0]   DIV_N   = NW'(DIVISOR);

  logic [NW+MW-1:0] p_q;
  logic [NW-1:0]    n_q;
  logic [MW-1:0]    q0;
  logic [NW-1:0]    r;
  mf_t              q_q;

  // Stage A: estimate, low by at most one
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q <= (NW+MW)'(num_i) * (NW+MW)'(RECIP);
      n_q <= num_i;
    end
  end

  // Stage B: remainder check and correction
  assign q0 = p_q[NW+MW-1:NW];
  assign r  = n_q - NW'(NW'(q0) * DIV_N);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q_q <= MF_W'(q0) + ((r >= DIV_N) ? MF_W'(1) : MF_W'(0));
    end
  end

  assign q_o = q_q;

endmodule

@@ sv/fbi_fuzz.sv @@
// Fuzzifier: five speed memberships and five neighbor memberships, four stages.
// Depends on fbi_pkg and fbi_cdiv.
module fbi_fuzz
  import fbi_pkg::*;
#(
  parameter int unsigned NEIGHBOR_MAX = 63
) (
  input  logic        clk_i,
  input  logic [3:0]  en_i,
  input  logic [13:0] speed_i,
  input  logic [5:0]  nbr_i,
  output mf_vec_t     ms_o,
  output mf_vec_t     mn_o
);

  logic [V_W-1:0] v;
  logic [7:0]     n_clip;
  seg_e           seg_d [5];
  seg_e           seg_q [5];
  logic [D_W-1:0] d_d   [5];
  logic [D_W-1:0] d_q   [5];
  logic [NW-1:0]  num_d [5];
  logic [NW-1:0]  num_q [5];
  mf_vec_t        mn_q  [4];

  // Scaled speed and clipped count
  assign v      = (V_W'(speed_i) << 2) + V_W'(speed_i);
  assign n_clip = ({2'b00, nbr_i} > 8'(NEIGHBOR_MAX)) ? 8'(NEIGHBOR_MAX) : {2'b00, nbr_i};

  for (genvar g = 0; g < 5; g++) begin : g_set
    localparam logic [NW-1:0] FULL_N = NW'(longint'(SET_DIV[g]) << 12);
    localparam logic [NW-1:0] HALF_N = NW'(SET_HALF[g]);
    logic [NW-1:0] sq;

    // Stage 0: which piece of the curve, and distance from its anchor
    always_comb begin
      seg_d[g] = SEG_ZERO;
      d_d[g]   = '0;
      case (SET_SHAPE[g])
        SHAPE_TRI: begin
          if (v >= SET_LO[g] && v <= SET_MID[g]) begin
            seg_d[g] = SEG_LO;
            d_d[g]   = D_W'(v - SET_LO[g]);
          end else if (v > SET_MID[g] && v < SET_HI[g]) begin
            seg_d[g] = SEG_HI;
            d_d[g]   = D_W'(SET_HI[g] - v);
          end
        end
        SHAPE_Z: begin
          if (v <= SET_LO[g]) begin
            seg_d[g] = SEG_FULL;
          end else if (v <= SET_MID[g]) begin
            seg_d[g] = SEG_LO;
            d_d[g]   = D_W'(v - SET_LO[g]);
          end else if (v <= SET_HI[g]) begin
            seg_d[g] = SEG_HI;
            d_d[g]   = D_W'(SET_HI[g] - v);
          end
        end
        default: begin
          if (v >= SET_HI[g]) begin
            seg_d[g] = SEG_FULL;
          end else if (v >= SET_LO[g] && v <= SET_MID[g]) begin
            seg_d[g] = SEG_LO;
            d_d[g]   = D_W'(v - SET_LO[g]);
          end else if (v > SET_MID[g]) begin
            seg_d[g] = SEG_HI;
            d_d[g]   = D_W'(SET_HI[g] - v);
          end
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        seg_q[g] <= seg_d[g];
        d_q[g]   <= d_d[g];
      end
    end

    // Stage 1: numerator of the rounded fraction over SET_DIV
    assign sq = NW'(2*D_W'(0) + (2*D_W)'(d_q[g]) * (2*D_W)'(d_q[g]));

    always_comb begin
      case (seg_q[g])
        SEG_FULL: num_d[g] = FULL_N;
        SEG_LO, SEG_HI: begin
          if (SET_SHAPE[g] == SHAPE_TRI) begin
            num_d[g] = (NW'(d_q[g]) << 6) + HALF_N;
          end else if ((SET_SHAPE[g] == SHAPE_Z) == (seg_q[g] == SEG_LO)) begin
            // quadratic half taken down from full membership
            num_d[g] = FULL_N + HALF_N - sq;
          end else begin
            num_d[g] = sq + HALF_N;
          end
        end
        default: num_d[g] = '0;
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        num_q[g] <= num_d[g];
      end
    end

    // Stages 2 and 3: division by the fixed divisor
    fbi_cdiv #(
      .DIVISOR(SET_DIV[g])
    ) u_cdiv (
      .clk_i(clk_i),
      .en_i (en_i[3:2]),
      .num_i(num_q[g]),
      .q_o  (ms_o[g])
    );
  end

  // Neighbor memberships from the table, kept in step with the speed path
  always_ff @(posedge clk_i) begin
    if (en_i[0]) mn_q[0] <= nbr_mf(n_clip);
    if (en_i[1]) mn_q[1] <= mn_q[0];
    if (en_i[2]) mn_q[2] <= mn_q[1];
    if (en_i[3]) mn_q[3] <= mn_q[2];
  end

  assign mn_o = mn_q[3];

endmodule

@@ sv/fbi_rules.sv @@
// Rule evaluation and aggregation: 25 min strengths, class sums, division request.
// Depends on fbi_pkg.
module fbi_rules
  import fbi_pkg::*;
(
  input  logic       clk_i,
  input  logic [3:0] en_i,
  input  mf_vec_t    ms_i,
  input  mf_vec_t    mn_i,
  output div_req_t   req_o
);

  mf_t               w_q  [5][5];
  logic [WS_W-1:0]   wc_d [5];
  logic [WS_W-1:0]   wc_q [5];
  logic [WS_W-1:0]   wsum_d;
  logic [CS_W-1:0]   csum_d;
  logic [WS_W-1:0]   wsum_q;
  logic [CS_W-1:0]   csum_q;
  div_req_t          req_q;

  // Stage 4: rule strengths
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          w_q[i][j] <= (ms_i[i] < mn_i[j]) ? ms_i[i] : mn_i[j];
        end
      end
    end
  end

  // Stage 5: strength per interval class
  always_comb begin
    for (int c = 0; c < 5; c++) wc_d[c] = '0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        wc_d[RULE_CLASS[i][j]] = wc_d[RULE_CLASS[i][j]] + WS_W'(w_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) wc_q <= wc_d;
  end

  // Stage 6: total strength and centroid-weighted sum
  always_comb begin
    wsum_d = '0;
    csum_d = '0;
    for (int c = 0; c < 5; c++) begin
      wsum_d = wsum_d + wc_q[c];
      csum_d = csum_d + CS_W'(CS_W'(CENTROID[c]) * CS_W'(wc_q[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      wsum_q <= wsum_d;
      csum_q <= csum_d;
    end
  end

  // Stage 7: rounded-quotient numerator and denominator
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      req_q.num    <= (RW'(csum_q) << 8) + RW'(RW'(50) * RW'(wsum_q));
      req_q.den    <= DEN_W'(DEN_W'(100) * DEN_W'(wsum_q));
      req_q.no_act <= (wsum_q == '0);
    end
  end

  assign req_o = req_q;

endmodule

@@ sv/fbi_div.sv @@
// Restoring divider, one quotient bit per pipeline stage, with empty-rule override.
// Depends on fbi_pkg.
module fbi_div
  import fbi_pkg::*;
(
  input  logic          clk_i,
  input  logic [QW-1:0] en_i,
  input  div_req_t      req_i,
  output logic [QW-1:0] interval_o,
  output logic          no_act_o
);

  logic [RW-1:0]    r_q  [QW];
  logic [DEN_W-1:0] d_q  [QW];
  logic [QW-1:0]    q_q  [QW];
  logic             na_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    logic [RW-1:0]    r_in;
    logic [DEN_W-1:0] d_in;
    logic [QW-1:0]    q_in;
    logic             na_in;
    logic [RW-1:0]    dsh;

    if (k == 0) begin : g_first
      assign r_in  = req_i.num;
      assign d_in  = req_i.den;
      assign q_in  = '0;
      assign na_in = req_i.no_act;
    end else begin : g_next
      assign r_in  = r_q[k-1];
      assign d_in  = d_q[k-1];
      assign q_in  = q_q[k-1];
      assign na_in = na_q[k-1];
    end

    assign dsh = RW'(d_in) << B;

    // Try the shifted divisor for this quotient bit
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        d_q[k]  <= d_in;
        na_q[k] <= na_in;
        if (r_in >= dsh) begin
          r_q[k] <= r_in - dsh;
          q_q[k] <= q_in | (QW'(1) << B);
        end else begin
          r_q[k] <= r_in;
          q_q[k] <= q_in;
        end
      end
    end
  end

  assign interval_o = na_q[QW-1] ? '0 : q_q[QW-1];
  assign no_act_o   = na_q[QW-1];

endmodule

@@ sv/fuzzy_beacon_interval_top.sv @@
// Fuzzy beacon interval engine: speed and neighbor count in, beacon period out.
// Fully pipelined: one request per cycle while the output is not stalled. The
// depth is set by the fuzzifier (four stages, the last two a fixed-divisor
// division), rule aggregation (four stages) and the one-bit-per-stage divider
// for the weighted centroid (eleven stages, one per interval bit).
// Back-pressure on the output stalls only the stages that are full; bubbles
// keep absorbing new requests. No rule firing yields interval 0 with the
// no-activation flag set. Reset clears only the stage valid bits.
module fuzzy_beacon_interval_top
  import fbi_pkg::*;
#(
  parameter int unsigned NEIGHBOR_MAX = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [13:0] speed_q, [19:14] neighbor_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] beacon_interval
  output logic        m_axis_tuser    // [0] no_activation
);

  localparam int unsigned DEPTH = 8 + QW;

  logic [DEPTH-1:0] en;
  mf_vec_t          ms;
  mf_vec_t          mn;
  div_req_t         req;
  logic [QW-1:0]    interval;
  logic             no_act;

  fbi_ctl #(
    .DEPTH(DEPTH)
  ) u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .en_o       (en)
  );

  fbi_fuzz #(
    .NEIGHBOR_MAX(NEIGHBOR_MAX)
  ) u_fuzz (
    .clk_i  (clk_i),
    .en_i   (en[3:0]),
    .speed_i(s_axis_tdata[13:0]),
    .nbr_i  (s_axis_tdata[19:14]),
    .ms_o   (ms),
    .mn_o   (mn)
  );

  fbi_rules u_rules (
    .clk_i(clk_i),
    .en_i (en[7:4]),
    .ms_i (ms),
    .mn_i (mn),
    .req_o(req)
  );

  fbi_div u_div (
    .clk_i     (clk_i),
    .en_i      (en[DEPTH-1:8]),
    .req_i     (req),
    .interval_o(interval),
    .no_act_o  (no_act)
  );

  assign m_axis_tdata = {5'b00000, interval};
  assign m_axis_tuser = no_act;

endmodule
